// ===== sv/ralu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_pkg
// shared types and constants for the register alu with status flags
// ----------------------------------------------------------------------------
package ralu_pkg;

	// width of the value fields on the ports
	localparam int VALUE_W = 16;
	// width of the request code and register index fields
	localparam int OP_W  = 4;
	localparam int IDX_W = 3;

	// register that comes out of reset with a nonzero value, and that value
	localparam int          SPECIAL_REG = 6;
	localparam logic [31:0] SPECIAL_VAL = 32'h0000_F000;

	// request codes; the unused code acts as read
	typedef enum logic [OP_W-1:0] {
		OP_XCHG  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_CMP   = 4'd5,
		OP_NOT   = 4'd6,
		OP_AND   = 4'd7,
		OP_OR    = 4'd8,
		OP_XOR   = 4'd9,
		OP_TEST  = 4'd10,
		OP_SHL   = 4'd11,
		OP_SHR   = 4'd12,
		OP_WRITE = 4'd13,
		OP_READ  = 4'd14
	} op_t;

	// status flags
	typedef struct packed {
		logic z;
		logic n;
		logic c;
		logic o;
	} flags_t;

endpackage

// ===== sv/register_alu_with_flags.sv =====
`timescale 1ns / 1ps
// sequence: after the input transfer the request passes ST_RD, ST_GO, ST_WAIT, ST_WB,
// ST_WB2 (xchg only) and ST_DONE; mul and div wait on the one-bit-per-cycle loop in the execution unit
// throughput: one item at a time; in_ready rises with out_valid, so a new item is taken
// only once the last result is loaded, and later while an earlier result is held
// reset: registers read as zero except register six (0xF000), flags clear; per-entry
// valid bits give these values at once, no clearing pass
// ----------------------------------------------------------------------------
// register_alu_with_flags
// two-register alu with z/n/c/o status flags on a small register file
// ----------------------------------------------------------------------------
module register_alu_with_flags #(
	parameter int NUM_REGS   = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ralu_pkg::OP_W-1:0]      req_type,
	input  logic [ralu_pkg::IDX_W-1:0]     dst_reg,
	input  logic [ralu_pkg::IDX_W-1:0]     src_reg,
	input  logic [ralu_pkg::VALUE_W-1:0]   write_value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ralu_pkg::VALUE_W-1:0]   dst_value,
	output logic [ralu_pkg::VALUE_W-1:0]   src_value,
	output logic                           flag_z,
	output logic                           flag_n,
	output logic                           flag_c,
	output logic                           flag_o
);
	import ralu_pkg::*;

	localparam int           W      = DATA_WIDTH;
	localparam int           AW     = $clog2(NUM_REGS);
	localparam logic [AW-1:0] SP_IDX = AW'(SPECIAL_REG % NUM_REGS);
	localparam logic [W-1:0]  SP_VAL = W'(SPECIAL_VAL);

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,	// waiting for a request transfer
		ST_RD   = 7'b0000010,	// register file read
		ST_GO   = 7'b0000100,	// start the execution unit
		ST_WAIT = 7'b0001000,	// wait for the execution unit
		ST_WB   = 7'b0010000,	// write destination
		ST_WB2  = 7'b0100000,	// write source (xchg only)
		ST_DONE = 7'b1000000	// load the output register
	} state_t;

	state_t        state_q;
	state_t        state_nx;

	// captured request
	op_t           op_q;
	logic [AW-1:0] di_q;
	logic [AW-1:0] si_q;
	logic [W-1:0]  wv_q;

	// register file storage and its reset tracking
	logic [W-1:0]        mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [W-1:0]        d_rd_q;
	logic [W-1:0]        s_rd_q;

	// single write port
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [W-1:0]  mem_wd;

	// operation outcome
	logic [W-1:0]  new_d_q;
	logic          wr_d_q;
	flags_t        status_q;

	// execution unit interface
	logic          ex_start;
	logic          ex_done;
	logic [W-1:0]  ex_res;
	flags_t        ex_flags;

	// values after the operation
	logic [W-1:0]  dst_fin;
	logic [W-1:0]  src_fin;

	// output register
	logic          out_valid_q;
	logic [W-1:0]  dst_out_q;
	logic [W-1:0]  src_out_q;
	flags_t        flg_out_q;

	logic in_xfer;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ex_start = (state_q == ST_GO);

	ralu_exec #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ex_start),
		.op       (op_q),
		.opa      (d_rd_q),
		.opb      (s_rd_q),
		.flags_in (status_q),
		.done     (ex_done),
		.result   (ex_res),
		.flags_out(ex_flags)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_nx = ST_RD;
			ST_RD:   state_nx = ST_GO;
			ST_GO:   state_nx = ST_WAIT;
			ST_WAIT: if (ex_done) state_nx = ST_WB;
			ST_WB:   state_nx = (op_q == OP_XCHG) ? ST_WB2 : ST_DONE;
			ST_WB2:  state_nx = ST_DONE;
			ST_DONE: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// capture the request on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q <= op_t'(req_type);
			di_q <= AW'(dst_reg);
			si_q <= AW'(src_reg);
			wv_q <= W'(write_value);
		end
	end

	// write port: destination first, then source for xchg
	always_comb begin
		mem_we = 1'b0;
		mem_wa = di_q;
		mem_wd = new_d_q;
		if (state_q == ST_WB) begin
			mem_we = wr_d_q;
		end else if (state_q == ST_WB2) begin
			mem_we = 1'b1;
			mem_wa = si_q;
			mem_wd = d_rd_q;
		end
	end

	// register file array, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_RD) begin
			// an entry never written reads as its reset value
			if (valid_q[di_q]) begin
				d_rd_q <= mem[di_q];
			end else begin
				d_rd_q <= (di_q == SP_IDX) ? SP_VAL : '0;
			end
			if (valid_q[si_q]) begin
				s_rd_q <= mem[si_q];
			end else begin
				s_rd_q <= (si_q == SP_IDX) ? SP_VAL : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[mem_wa] <= 1'b1;
		end
	end

	// pick the destination update once the execution unit is done
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && ex_done) begin
			case (op_q) inside
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NOT, OP_AND, OP_OR, OP_XOR,
				OP_SHL, OP_SHR: begin
					new_d_q <= ex_res;
					wr_d_q  <= 1'b1;
				end
				OP_WRITE: begin
					new_d_q <= wv_q;
					wr_d_q  <= 1'b1;
				end
				OP_XCHG: begin
					new_d_q <= s_rd_q;
					wr_d_q  <= 1'b1;
				end
				default: begin
					new_d_q <= d_rd_q;
					wr_d_q  <= 1'b0;
				end
			endcase
		end
	end

	// status flags: the unit passes them through for operations that keep them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
		end else if (state_q == ST_WAIT && ex_done) begin
			status_q <= ex_flags;
		end
	end

	// register contents after the operation; same index on both sides
	// reports the final value of that one register twice
	assign dst_fin = wr_d_q ? new_d_q : d_rd_q;
	assign src_fin = (si_q == di_q) ? dst_fin : ((op_q == OP_XCHG) ? d_rd_q : s_rd_q);

	// output register, frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			dst_out_q <= dst_fin;
			src_out_q <= src_fin;
			flg_out_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign dst_value = VALUE_W'(dst_out_q);
	assign src_value = VALUE_W'(src_out_q);
	assign flag_z    = flg_out_q.z;
	assign flag_n    = flg_out_q.n;
	assign flag_c    = flg_out_q.c;
	assign flag_o    = flg_out_q.o;

endmodule

// ===== sv/ralu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_exec
// execution unit: one shared add/subtract path, single-step logic and shift
// operations, shift-add multiply and restoring divide over DATA_WIDTH steps
// ----------------------------------------------------------------------------
module ralu_exec #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ralu_pkg::op_t         op,
	input  logic [DATA_WIDTH-1:0] opa,
	input  logic [DATA_WIDTH-1:0] opb,
	input  ralu_pkg::flags_t      flags_in,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result,
	output ralu_pkg::flags_t      flags_out
);
	import ralu_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic          done_q;
	op_t           op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  aux_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  res_q;
	flags_t        flg_q;

	logic [W+1:0]  add_x;
	logic [W+1:0]  add_y;
	logic [W+1:0]  sum;
	logic          add_sub;
	logic [W-1:0]  ovf_v;
	logic [W-1:0]  one_res;
	flags_t        one_flg;
	logic [W-1:0]  mul_acc;
	logic          no_borrow;
	logic [W-1:0]  div_acc;
	logic [W-1:0]  div_quo;

	// shared adder, operands picked by the active operation
	// on a subtract the top bit of sum is set when it borrows
	always_comb begin
		add_x   = {2'b00, opa};
		add_y   = {2'b00, opb};
		add_sub = (op != OP_ADD);
		if (run_q) begin
			if (op_q == OP_MUL) begin
				add_x   = {2'b00, acc_q};
				add_y   = {2'b00, aux_q};
				add_sub = 1'b0;
			end else begin
				// partial remainder shifted left with the next dividend bit
				add_x   = {1'b0, acc_q, aux_q[W-1]};
				add_y   = {2'b00, b_q};
				add_sub = 1'b1;
			end
		end
		sum = add_x + (add_y ^ {(W+2){add_sub}}) + (W+2)'(add_sub);
	end

	assign ovf_v = (opa ^ opb) & (opa ^ sum[W-1:0]);

	// operations finished in one step
	always_comb begin
		one_res = opa;
		one_flg = flags_in;
		case (op) inside
			OP_ADD, OP_SUB: one_res = sum[W-1:0];
			OP_CMP: begin
				one_flg.z = (sum[W-1:0] == '0);
				one_flg.n = sum[W-1];
				one_flg.c = sum[W+1];
				one_flg.o = ovf_v[W-1];
			end
			OP_NOT:  one_res = ~opa;
			OP_AND:  one_res = opa & opb;
			OP_OR:   one_res = opa | opb;
			OP_XOR:  one_res = opa ^ opb;
			OP_TEST: one_flg.z = ((opa & opb) == '0);
			OP_SHL: begin
				one_res   = opa << opb;
				one_flg.z = ((opa << opb) == '0);
				one_flg.n = one_res[W-1];
			end
			OP_SHR: begin
				one_res   = opa >> opb;
				one_flg.z = ((opa >> opb) == '0);
				one_flg.n = one_res[W-1];
			end
			default: ;
		endcase
	end

	// next step of multiply and divide
	assign mul_acc   = b_q[0] ? sum[W-1:0] : acc_q;
	assign no_borrow = ~sum[W+1];
	assign div_acc   = no_borrow ? sum[W-1:0] : {acc_q[W-2:0], aux_q[W-1]};
	assign div_quo   = {aux_q[W-2:0], no_borrow};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_READ;
		end else if (start) begin
			op_q <= op;
			if (op == OP_MUL || op == OP_DIV) begin
				run_q  <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(W);
			end else begin
				done_q <= 1'b1;
			end
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			aux_q <= opa;
			b_q   <= opb;
			res_q <= one_res;
			flg_q <= one_flg;
		end else if (run_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= mul_acc;
				aux_q <= aux_q << 1;
				b_q   <= b_q >> 1;
				res_q <= mul_acc;
			end else begin
				acc_q <= div_acc;
				aux_q <= div_quo;
				res_q <= div_quo;
			end
		end
	end

	assign done      = done_q;
	assign result    = res_q;
	assign flags_out = flg_q;

endmodule
